@@ hw/rtl/isort_pkg.sv @@
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the streaming insertion sorter: the
// transaction payloads, the link between neighboring cells and cell control.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        value_t in_value;
        logic   in_last;
    } in_item_t;

    typedef struct packed {
        value_t out_value;
        logic   out_last;
        logic   out_overflow;
    } out_item_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        value_t value;
        logic   occ;
        logic   gt;
    } cell_link_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/insertion_sorter_top.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_top
// Streaming insertion sorter for signed Q16.16 values built from a chain of
// compare-and-shift cells; the run closes on the item marked last.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    in_item_t
//   result    out        result_valid / result_stall out_item_t
//
// While filling, one item is accepted every cycle; every cell compares in
// parallel, so the insertion time does not depend on the fill level.
// After the last item the chain shifts down toward cell zero, one result per
// taken transaction, until every stored value has been taken;
// item_stall is high for that whole drain. result_stall simply freezes the
// chain. Reset empties the chain at once and needs no clearing pass.
// ----------------------------------------------------------------------------
module insertion_sorter_top #(
    parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  isort_pkg::in_item_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output isort_pkg::out_item_t  result
);
    import isort_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic          dropped_reg;

    cell_link_t    links [DEPTH];
    cell_ctrl_t    ctrl;
    logic          item_take;
    logic          result_take;
    logic          full;

    assign full        = links[DEPTH-1].occ;
    assign item_stall  = (state_reg == S_DRAIN);
    assign item_take   = item_valid && !item_stall;
    assign result_take = result_valid && !result_stall;

    assign ctrl.ins   = item_take && !full;
    assign ctrl.shift = (state_reg == S_DRAIN) && result_take;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_link_t prev_l;
            cell_link_t next_l;

            if (gi == 0)
            begin : g_head
                assign prev_l = '{value: '0, occ: 1'b1, gt: 1'b0};
            end
            else
            begin : g_body
                assign prev_l = links[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_l = '{value: '0, occ: 1'b0, gt: 1'b0};
            end
            else
            begin : g_inner
                assign next_l = links[gi+1];
            end

            isort_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .bcast (item.in_value),
                .prev  (prev_l),
                .next  (next_l),
                .link  (links[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_FILL:
                begin
                    if (item_take)
                    begin
                        if (full)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        if (item.in_last)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (result_take)
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            state_reg   <= S_FILL;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

    // The smallest stored value always sits in the first cell.
    assign result_valid        = (state_reg == S_DRAIN);
    assign result.out_value    = links[0].value;
    assign result.out_last     = (count_reg == CW'(1));
    assign result.out_overflow = dropped_reg;

endmodule

@@ hw/rtl/isort_cell.sv @@
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain. It holds a value and an occupied flag,
// compares the broadcast value against its own, and hands its value to the
// neighbor above on insert or to the neighbor below while the run drains.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  isort_pkg::value_t      bcast,
    input  isort_pkg::cell_link_t  prev,
    input  isort_pkg::cell_link_t  next,
    output isort_pkg::cell_link_t  link
);
    import isort_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   occ_reg;
    logic   occ_next;
    logic   gt;

    // Strict compare keeps equal values in arrival order.
    assign gt = occ_reg && (value_reg > bcast);

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (ctrl.shift)
        begin
            value_next = next.value;
            occ_next   = next.occ;
        end
        else if (ctrl.ins)
        begin
            // A cell moves up when its value is larger, or fills when empty.
            if (gt || !occ_reg)
            begin
                value_next = prev.gt ? prev.value : bcast;
            end
            occ_next = occ_reg | prev.occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.occ   = occ_reg;
    assign link.gt    = gt;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: insertion_sorter_top testbench
// Feeds runs of signed Q16.16 values through the valid/stall item channel
// and checks every sorted result against an insertion-sort predictor kept
// in a small scoreboard. Runs cover single elements, duplicates, the value
// extremes, a store filled exactly and runs that overflow it. Both channels
// idle and stall at random, with one stretch of full throughput.
// ----------------------------------------------------------------------------

class sort_scoreboard;
    int unsigned          depth;
    isort_pkg::value_t    held[$];
    bit                   dropped;
    isort_pkg::out_item_t sorted_due[$];
    int unsigned          errors;
    int unsigned          runs;
    int unsigned          overflow_runs;
    int unsigned          results;

    function new(int unsigned d);
        depth         = d;
        dropped       = 1'b0;
        errors        = 0;
        runs          = 0;
        overflow_runs = 0;
        results       = 0;
    endfunction

    // Inserts one accepted element; on the closing element, queues the run.
    function void add_element(isort_pkg::in_item_t it);
        int unsigned          pos;
        isort_pkg::out_item_t r;
        if (held.size() >= depth)
        begin
            dropped = 1'b1;
        end
        else
        begin
            // Equal values stay behind earlier arrivals.
            pos = 0;
            while (pos < held.size() && $signed(held[pos]) <= $signed(it.in_value))
                pos++;
            held.insert(pos, it.in_value);
        end
        if (it.in_last)
        begin
            foreach (held[k])
            begin
                r.out_value    = held[k];
                r.out_last     = (k == held.size() - 1);
                r.out_overflow = dropped;
                sorted_due.push_back(r);
            end
            runs++;
            if (dropped)
                overflow_runs++;
            held.delete();
            dropped = 1'b0;
        end
    endfunction

    function void check_sorted(isort_pkg::out_item_t got);
        isort_pkg::out_item_t want;
        if (sorted_due.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing expected: value=%h last=%b overflow=%b",
                     $time, got.out_value, got.out_last, got.out_overflow);
            return;
        end
        want = sorted_due.pop_front();
        results++;
        if (got.out_value !== want.out_value)
        begin
            errors++;
            $display("%0t: out_value expected %h actual %h",
                     $time, want.out_value, got.out_value);
        end
        if (got.out_last !== want.out_last)
        begin
            errors++;
            $display("%0t: out_last expected %b actual %b",
                     $time, want.out_last, got.out_last);
        end
        if (got.out_overflow !== want.out_overflow)
        begin
            errors++;
            $display("%0t: out_overflow expected %b actual %b",
                     $time, want.out_overflow, got.out_overflow);
        end
    endfunction
endclass

module tb;
    import isort_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int IDLE_PCT     = 23;
    localparam int RANDOM_ITEMS = 420;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = DEPTH + 8;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    bit          calm        = 1'b0;
    int unsigned items_sent  = 0;
    int unsigned idle_cycles = 0;

    sort_scoreboard board = new(DEPTH);

    insertion_sorter_top #(.DEPTH(DEPTH)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                board.add_element(item);
            if (result_valid && !result_stall)
                board.check_sorted(result);
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input value_t v, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{in_value: v, in_last: last};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Holds the sender back until every queued result has come out.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.sorted_due.size() != 0);
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return value_t'(32'h8000_0000);
            1:       return value_t'(32'h7FFF_FFFF);
            2:       return value_t'($signed($urandom_range(0, 6)) - 3);
            3:       return value_t'($urandom() & 32'hFFFF_0000);
            default: return value_t'($urandom());
        endcase
    endfunction

    task automatic send_run(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    initial
    begin
        int unsigned len;
        int unsigned run_idx;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A run of one element.
        send_item(value_t'(32'h7FFF_FFFF), 1'b1);
        // Both extremes, zero, minus one and a duplicate pair.
        send_item(value_t'(32'h8000_0000), 1'b0);
        send_item(value_t'(32'h7FFF_FFFF), 1'b0);
        send_item(value_t'(0), 1'b0);
        send_item(value_t'(-1), 1'b0);
        send_item(value_t'(32'h0005_0000), 1'b0);
        send_item(value_t'(32'h0005_0000), 1'b1);
        // Descending run that fills the store; the closing element is dropped.
        for (int i = 0; i < DEPTH + 1; i++)
        begin
            if (i == DEPTH)
                send_item(value_t'(32'h8000_0000), 1'b1);
            else
                send_item(value_t'((8 - i) * 65536), 1'b0);
        end
        wait_drained();

        run_idx = 0;
        while (items_sent < DEPTH + 8 + RANDOM_ITEMS)
        begin
            calm <= (items_sent >= 180 && items_sent < 290);
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = DEPTH;
                2:       len = DEPTH + 1 + $urandom_range(0, 6);
                default: len = $urandom_range(2, DEPTH - 1);
            endcase
            send_run(len);
            run_idx++;
            if (run_idx == 12)
                wait_drained();
        end
        calm <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d elements in %0d runs, %0d of them overflowing the store.",
                 items_sent, board.runs, board.overflow_runs);
        $display("Checked %0d sorted results, %0d mismatches.", board.results, board.errors);
        if (board.errors == 0 && board.sorted_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
